[rtl/cpd_pkg.sv]
// Shared types and constants for the constrained Pareto dominance block.
// Used by cpd_accum, cpd_verdict and the top level; depends on nothing.
package cpd_pkg;

  // Default width of one solution element (signed fixed point).
  localparam int VALUE_WIDTH_DEF = 32;

  // Width of the saturating violation sums.
  localparam int SUM_W = 40;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PENALTY_MODE = 1'b0;  // word select paddr[2] of penalty_mode

  // Result widths.
  localparam int VERDICT_W  = 2;
  localparam int OUT_DATA_W = 8;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_NONE   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FIRST  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_SECOND = 2'd2;

  // Everything the verdict stage needs about one finished comparison.
  typedef struct packed {
    logic [SUM_W-1:0] viol_first;
    logic [SUM_W-1:0] viol_second;
    logic             first_smaller;
    logic             second_smaller;
  } snap_t;

endpackage

[rtl/cpd_accum.sv]
// Accumulation stage: violation sums and objective flags per comparison.
// Depends on cpd_pkg; hands a snapshot of each finished comparison onward.
module cpd_accum
  import cpd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   item_objective,
  input  logic [VALUE_WIDTH-1:0] item_first,
  input  logic [VALUE_WIDTH-1:0] item_second,
  input  logic                   item_last,
  output logic                   snap_valid,
  input  logic                   snap_ready,
  output snap_t                  snap
);

  localparam int EXT_W = ((VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W) + 1;
  localparam logic signed [EXT_W-1:0] SUM_MIN_EXT =
    {{(EXT_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

  logic [SUM_W-1:0] viol_first_r, viol_first_nxt;
  logic [SUM_W-1:0] viol_second_r, viol_second_nxt;
  logic             first_smaller_r, first_smaller_nxt;
  logic             second_smaller_r, second_smaller_nxt;
  logic             snap_valid_r, snap_valid_nxt;
  snap_t            snap_r, snap_nxt;
  logic             fire;
  logic signed [EXT_W-1:0] sum_first, sum_second;
  logic [SUM_W-1:0] upd_first, upd_second;

  // Adds the negative part of a value into a sum, clamping at the 40-bit minimum.
  function automatic logic signed [EXT_W-1:0] add_neg(
    input logic [SUM_W-1:0]       acc,
    input logic [VALUE_WIDTH-1:0] v
  );
    logic signed [EXT_W-1:0] acc_ext;
    logic signed [EXT_W-1:0] v_ext;
    logic signed [EXT_W-1:0] s;
    acc_ext = {{(EXT_W-SUM_W){acc[SUM_W-1]}}, acc};
    v_ext   = {{(EXT_W-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
    if (!v[VALUE_WIDTH-1]) begin
      s = acc_ext;
    end else begin
      s = acc_ext + v_ext;
      if (s < SUM_MIN_EXT) begin
        s = SUM_MIN_EXT;
      end
    end
    return s;
  endfunction

  // Non-last items never need the snapshot register, so they always move on.
  assign item_ready = !item_last || !snap_valid_r || snap_ready;
  assign fire       = item_valid && item_ready;

  assign sum_first  = add_neg(viol_first_r, item_first);
  assign sum_second = add_neg(viol_second_r, item_second);

  always_comb begin
    upd_first          = viol_first_r;
    upd_second         = viol_second_r;
    first_smaller_nxt  = first_smaller_r;
    second_smaller_nxt = second_smaller_r;
    if (item_objective) begin
      if ($signed(item_first) < $signed(item_second)) begin
        first_smaller_nxt = 1'b1;
      end else if ($signed(item_first) > $signed(item_second)) begin
        second_smaller_nxt = 1'b1;
      end
    end else begin
      upd_first  = sum_first[SUM_W-1:0];
      upd_second = sum_second[SUM_W-1:0];
    end

    snap_nxt.viol_first     = upd_first;
    snap_nxt.viol_second    = upd_second;
    snap_nxt.first_smaller  = first_smaller_nxt;
    snap_nxt.second_smaller = second_smaller_nxt;

    viol_first_nxt  = upd_first;
    viol_second_nxt = upd_second;
    if (item_last) begin
      viol_first_nxt     = '0;
      viol_second_nxt    = '0;
      first_smaller_nxt  = 1'b0;
      second_smaller_nxt = 1'b0;
    end

    snap_valid_nxt = snap_valid_r && !snap_ready;
    if (fire && item_last) begin
      snap_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      viol_first_r     <= '0;
      viol_second_r    <= '0;
      first_smaller_r  <= 1'b0;
      second_smaller_r <= 1'b0;
      snap_valid_r     <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      if (fire) begin
        viol_first_r     <= viol_first_nxt;
        viol_second_r    <= viol_second_nxt;
        first_smaller_r  <= first_smaller_nxt;
        second_smaller_r <= second_smaller_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item_last) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule

[rtl/cpd_verdict.sv]
// Verdict stage: turns a comparison snapshot into the registered result.
// Depends on cpd_pkg; fed by cpd_accum, drives the result channel.
module cpd_verdict
  import cpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 penalty_mode,
  input  logic                 snap_valid,
  output logic                 snap_ready,
  input  snap_t                snap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] verdict
);

  logic                 out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic                 neg_first, neg_second;

  assign snap_ready = !out_valid_r || out_ready;
  assign neg_first  = snap.viol_first[SUM_W-1];
  assign neg_second = snap.viol_second[SUM_W-1];

  always_comb begin
    if (snap.first_smaller && !snap.second_smaller) begin
      verdict_nxt = VERDICT_FIRST;
    end else if (!snap.first_smaller && snap.second_smaller) begin
      verdict_nxt = VERDICT_SECOND;
    end else begin
      verdict_nxt = VERDICT_NONE;
    end
    // Feasibility overrides objectives unless penalties are handled elsewhere.
    if (!penalty_mode) begin
      if (neg_first && neg_second) begin
        if ($signed(snap.viol_first) > $signed(snap.viol_second)) begin
          verdict_nxt = VERDICT_FIRST;
        end else if ($signed(snap.viol_first) < $signed(snap.viol_second)) begin
          verdict_nxt = VERDICT_SECOND;
        end else begin
          verdict_nxt = VERDICT_NONE;
        end
      end else if (neg_first) begin
        verdict_nxt = VERDICT_SECOND;
      end else if (neg_second) begin
        verdict_nxt = VERDICT_FIRST;
      end
    end
    out_valid_nxt = (out_valid_r && !out_ready) || snap_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign verdict   = verdict_r;

endmodule

[rtl/constrained_pareto_dominance.sv]
// Top level of the constrained Pareto dominance checker: input register,
// configuration register and the two stages. Depends on cpd_pkg, cpd_accum, cpd_verdict.
//
//   Channel  Direction  Handshake              Contents
//   in_      slave      tvalid/tready          value pair, kind in tuser, end in tlast
//   out_     master     tvalid/tready          verdict, one per comparison
//   cfg_     APB slave  psel/penable/pready    penalty_mode at byte address 0
//
// One element pair is accepted in every cycle unless a stalled result holds it back; a
// verdict is offered once its last pair has passed input, snapshot and result registers.
// The accumulator stage, one saturating add per sum, sets the one-item-per-cycle rate.
// Reset is synchronous and active low; it clears the sums, the flags, penalty_mode
// and all valid bits. A stalled result fills the result and snapshot registers; a
// further last pair then waits in the input register and stalls the input channel.
module constrained_pareto_dominance
  import cpd_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, lowest bit first: value_first, value_second, zero fill to a whole byte.
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  // tuser: is_objective (0 = constraint pair, 1 = objective pair).
  input  logic                              in_tuser,
  // tlast: last_element, the final pair of a comparison.
  input  logic                              in_tlast,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, lowest bit first: verdict (2 bits), zero fill to a whole byte.
  output logic [OUT_DATA_W-1:0]             out_tdata,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]             cfg_paddr,
  input  logic [CFG_DATA_W-1:0]             cfg_pwdata,
  output logic [CFG_DATA_W-1:0]             cfg_prdata,
  output logic                              cfg_pready
);

  // Input register: one element pair waiting for the accumulator.
  logic                   in_valid_r, in_valid_nxt;
  logic                   in_objective_r;
  logic [VALUE_WIDTH-1:0] in_first_r;
  logic [VALUE_WIDTH-1:0] in_second_r;
  logic                   in_last_r;
  logic                   item_ready;
  logic                   in_fire;

  // Configuration register.
  logic penalty_mode_r, penalty_mode_nxt;
  logic cfg_hit;

  // Between the stages.
  logic                 snap_valid;
  logic                 snap_ready;
  snap_t                snap;
  logic [VERDICT_W-1:0] verdict;

  // The input register takes a new pair whenever it is empty or being drained.
  assign in_tready    = !in_valid_r || item_ready;
  assign in_fire      = in_tvalid && in_tready;
  assign in_valid_nxt = in_fire || (in_valid_r && !item_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_objective_r <= in_tuser;
      in_first_r     <= in_tdata[VALUE_WIDTH-1:0];
      in_second_r    <= in_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
      in_last_r      <= in_tlast;
    end
  end

  // The register is written in the access phase; only word 0 exists, and other
  // words read as zero and ignore writes.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_PENALTY_MODE);

  always_comb begin
    penalty_mode_nxt = penalty_mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      penalty_mode_nxt = cfg_pwdata[0];
    end
    cfg_prdata = cfg_hit ? {{(CFG_DATA_W-1){1'b0}}, penalty_mode_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_mode_r <= 1'b0;
    end else begin
      penalty_mode_r <= penalty_mode_nxt;
    end
  end

  cpd_accum #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (in_valid_r),
    .item_ready     (item_ready),
    .item_objective (in_objective_r),
    .item_first     (in_first_r),
    .item_second    (in_second_r),
    .item_last      (in_last_r),
    .snap_valid     (snap_valid),
    .snap_ready     (snap_ready),
    .snap           (snap)
  );

  cpd_verdict u_verdict (
    .clk          (clk),
    .rst_n        (rst_n),
    .penalty_mode (penalty_mode_r),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .verdict      (verdict)
  );

  assign out_tdata = {{(OUT_DATA_W-VERDICT_W){1'b0}}, verdict};

endmodule

[bench/constrained_pareto_dominance_tb.sv]
// Self-checking testbench for constrained_pareto_dominance: element pairs are streamed
// in, and every verdict is compared with a scoreboard predicted inside the bench.
// Depends on cpd_pkg and the constrained_pareto_dominance RTL only.
`timescale 1ns / 100ps

module constrained_pareto_dominance_tb;
  import cpd_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int IN_DATA_W = ((2*VW+7)/8)*8;

  // How long the receiver refuses results during the back-pressure test.
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the hold-off above.
  localparam int STALL_LIMIT = 3000;
  // Settling time after the last verdict; the pipeline is three stages deep.
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CFG_ADDR_W-1:0] ADDR_PENALTY_MODE = {REG_PENALTY_MODE, 2'b00};

  // Kinds of element pair, carried on in_tuser.
  localparam logic KIND_CONSTRAINT = 1'b0;
  localparam logic KIND_OBJECTIVE  = 1'b1;

  localparam logic [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] V_NEG_ONE = '1;
  localparam logic [VW-1:0] V_ZERO = '0;

  // Most negative value a violation sum may reach.
  localparam longint SUM_FLOOR = -(longint'(1) <<< (SUM_W-1));

  typedef struct packed {
    logic                 is_objective;
    logic signed [VW-1:0] value_first;
    logic signed [VW-1:0] value_second;
    logic                 last_element;
  } elem_pair_t;

  // Shapes of a random comparison.
  typedef enum {SHAPE_MIXED, SHAPE_OBJECTIVES, SHAPE_CONSTRAINTS, SHAPE_TIED_CONSTRAINTS} shape_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Mirror of the block's state, kept by the predictor.
  logic   penalty_skip;
  longint viol_first_sum;
  longint viol_second_sum;
  logic   first_lower;
  logic   second_lower;

  // Verdicts predicted but not yet seen on the result channel, oldest first.
  logic [VERDICT_W-1:0] pending_verdicts[$];

  // Stimulus controls and run statistics.
  bit send_idle;
  bit recv_idle;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int n_errors;
  int pairs_sent;
  int verdicts_seen[3];
  int input_stall_cycles;

  constrained_pareto_dominance #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. A violation sum only ever collects negative values and stops
  // at the 40-bit minimum instead of wrapping.
  // ---------------------------------------------------------------------------
  function automatic longint saturating_violation(input longint sum, input longint v);
    if (v >= 0) return sum;
    if (sum + v < SUM_FLOOR) return SUM_FLOOR;
    return sum + v;
  endfunction

  // Folds one accepted pair into the mirrored state; a pair marked last
  // produces the expected verdict and clears everything for the next comparison.
  task automatic score_pair(input elem_pair_t p);
    longint a;
    longint b;
    logic [VERDICT_W-1:0] v;
    a = p.value_first;
    b = p.value_second;
    if (p.is_objective == KIND_OBJECTIVE) begin
      // Equal objective values mark neither side.
      if (a < b) first_lower = 1'b1;
      else if (a > b) second_lower = 1'b1;
    end else begin
      viol_first_sum = saturating_violation(viol_first_sum, a);
      viol_second_sum = saturating_violation(viol_second_sum, b);
    end
    if (!p.last_element) return;

    // Plain minimization dominance.
    if (first_lower && !second_lower) v = VERDICT_FIRST;
    else if (!first_lower && second_lower) v = VERDICT_SECOND;
    else v = VERDICT_NONE;

    // With constraint checking on, any violation outranks the objectives:
    // the smaller violation wins, and a feasible side beats an infeasible one.
    if (!penalty_skip) begin
      if (viol_first_sum < 0 && viol_second_sum < 0) begin
        if (viol_first_sum > viol_second_sum) v = VERDICT_FIRST;
        else if (viol_first_sum < viol_second_sum) v = VERDICT_SECOND;
        else v = VERDICT_NONE;
      end else if (viol_first_sum < 0) begin
        v = VERDICT_SECOND;
      end else if (viol_second_sum < 0) begin
        v = VERDICT_FIRST;
      end
    end

    pending_verdicts = {pending_verdicts, v};
    viol_first_sum = 0;
    viol_second_sum = 0;
    first_lower = 1'b0;
    second_lower = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. The task is entered just after a falling edge and returns just
  // after one, leaving in_tvalid high so back-to-back transfers need no gap.
  // ---------------------------------------------------------------------------
  task automatic send_pair(input elem_pair_t p);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[VW-1:0] = p.value_first;
    d[2*VW-1:VW] = p.value_second;
    while (send_idle && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= p.is_objective;
    in_tlast <= p.last_element;
    do @(posedge clk); while (!in_tready);
    score_pair(p);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic offer(input logic kind, input logic [VW-1:0] a, input logic [VW-1:0] b,
                       input logic last);
    elem_pair_t p;
    p.is_objective = kind;
    p.value_first = a;
    p.value_second = b;
    p.last_element = last;
    send_pair(p);
  endtask

  // Stops offering and waits until every predicted verdict has come back and
  // the pipeline has had time to settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port: setup cycle, then access cycle until pready.
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_PENALTY_MODE) penalty_skip = data[0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_read(input logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_penalty_readback();
    logic [CFG_DATA_W-1:0] got;
    logic [CFG_DATA_W-1:0] want;
    want = '0;
    want[0] = penalty_skip;
    cfg_read(ADDR_PENALTY_MODE, got);
    if (got !== want) begin
      $display("%0t: penalty_mode readback mismatch, expected %0h, actual %0h",
               $time, want, got);
      n_errors++;
    end
  endtask

  // Only called once nothing is in flight. The unused upper bits of the
  // write data are random; only bit 0 is the register.
  task automatic set_penalty_mode(input logic skip);
    logic [CFG_DATA_W-1:0] word;
    wait_drained();
    word = $urandom;
    word[0] = skip;
    cfg_write(ADDR_PENALTY_MODE, word);
    check_penalty_readback();
  endtask

  // ---------------------------------------------------------------------------
  // Random values: a mix of full-range words, values near zero (so equal and
  // off-by-one pairs are common), extremes, negatives and whole Q15.16 numbers.
  // ---------------------------------------------------------------------------
  function automatic logic [VW-1:0] rand_value();
    int s;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: begin
        s = $urandom_range(0, 16);
        return s - 8;
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return V_MIN;
          1: return V_MAX;
          2: return V_ZERO;
          default: return V_NEG_ONE;
        endcase
      end
      3: return $urandom | V_MIN;
      default: begin
        s = $urandom_range(0, 2000);
        return (s - 1000) <<< 16;
      end
    endcase
  endfunction

  // Sends whole comparisons of random length and content until n_items pairs
  // have been transferred. Every comparison ends with a pair marked last.
  task automatic run_random(input int n_items);
    int sent;
    int len;
    int i;
    int r;
    shape_t shape;
    elem_pair_t p;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      shape = shape_t'($urandom_range(0, 3));
      for (i = 0; i < len; i++) begin
        case (shape)
          SHAPE_OBJECTIVES: p.is_objective = KIND_OBJECTIVE;
          SHAPE_CONSTRAINTS: p.is_objective = KIND_CONSTRAINT;
          default: p.is_objective = 1'($urandom_range(0, 1));
        endcase
        p.value_first = rand_value();
        r = $urandom_range(0, 9);
        // Tied constraint comparisons give equal violation sums on both sides.
        if ((shape == SHAPE_TIED_CONSTRAINTS && p.is_objective == KIND_CONSTRAINT) || r < 2)
          p.value_second = p.value_first;
        else if (r < 4)
          p.value_second = p.value_first + ((r == 2) ? 1 : -1);
        else
          p.value_second = rand_value();
        p.last_element = (i == len - 1);
        send_pair(p);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // penalty_mode must come out of reset as zero.
  task automatic test_reset_value();
    check_penalty_readback();
  endtask

  // Hand-picked comparisons with constraint checking on.
  task automatic test_directed_constrained();
    offer(KIND_OBJECTIVE, 1, 2, 1'b1);                 // first smaller
    offer(KIND_OBJECTIVE, 5, 5, 1'b1);                 // equal objectives: no flag
    offer(KIND_OBJECTIVE, V_MIN, V_MAX, 1'b1);         // extremes, first wins
    offer(KIND_OBJECTIVE, V_MAX, V_MIN, 1'b1);         // extremes, second wins
    offer(KIND_OBJECTIVE, 1, 2, 1'b0);                 // each side better once
    offer(KIND_OBJECTIVE, 3, 2, 1'b1);
    offer(KIND_CONSTRAINT, V_ZERO, V_MAX, 1'b0);       // non-negative constraints add nothing
    offer(KIND_OBJECTIVE, 7, 3, 1'b1);
    offer(KIND_CONSTRAINT, V_NEG_ONE, V_ZERO, 1'b1);   // only first violates
    offer(KIND_CONSTRAINT, V_ZERO, V_NEG_ONE, 1'b0);   // only second violates, beats objectives
    offer(KIND_OBJECTIVE, V_MIN, V_MAX, 1'b1);
    offer(KIND_CONSTRAINT, V_MIN, V_MIN, 1'b0);        // equal violations tie
    offer(KIND_OBJECTIVE, 0, 1, 1'b1);
    offer(KIND_CONSTRAINT, -3, -5, 1'b0);              // both violate, sums -7 and -6
    offer(KIND_CONSTRAINT, -4, -1, 1'b1);
    offer(KIND_CONSTRAINT, -2, -9, 1'b0);              // smaller violation overrides objectives
    offer(KIND_OBJECTIVE, 9, 0, 1'b1);
  endtask

  // Long runs of the most negative constraint value drive the sums into the
  // 40-bit floor: both pinned there tie, and a sum just above it wins.
  task automatic test_violation_saturation();
    int i;
    for (i = 0; i < 258; i++)
      offer(KIND_CONSTRAINT, V_MIN, V_MIN, i == 257);
    for (i = 0; i < 260; i++)
      offer(KIND_CONSTRAINT, V_MIN, (i < 255) ? V_MIN : ((i == 255) ? V_NEG_ONE : V_ZERO),
            i == 259);
  endtask

  // With penalty_mode set, violations are ignored and objectives decide.
  task automatic test_penalty_skip();
    set_penalty_mode(1'b1);
    offer(KIND_CONSTRAINT, V_NEG_ONE, V_ZERO, 1'b0);
    offer(KIND_OBJECTIVE, 1, 2, 1'b1);
    offer(KIND_CONSTRAINT, V_MIN, V_MIN, 1'b0);
    offer(KIND_OBJECTIVE, 4, 3, 1'b1);
    offer(KIND_CONSTRAINT, -5, V_ZERO, 1'b1);
  endtask

  // Random comparisons in phases that alternate the penalty mode.
  task automatic test_random_modes();
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      set_penalty_mode(ph[0] ? 1'b0 : 1'b1);
      run_random(250);
    end
  endtask

  // A long stretch with neither side idling.
  task automatic test_back_to_back();
    set_penalty_mode(1'b0);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_random(200);
    wait_drained();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // The receiver refuses results for a long time while single-pair
  // comparisons keep coming, so the block fills and must stall its input.
  task automatic test_result_backpressure();
    int i;
    wait_drained();
    @(posedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    hold_req = 1'b0;
    @(negedge clk);
    send_idle = 1'b0;
    for (i = 0; i < 80; i++)
      offer(i[0] ? KIND_OBJECTIVE : KIND_CONSTRAINT, rand_value(), rand_value(), 1'b1);
    send_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, with an optional long hold-off counted here.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_OFF_CYCLES;
    end else begin
      out_tready <= !recv_idle || ($urandom_range(0, 99) >= 20);
    end
  end

  // Every result transfer is matched against the oldest predicted verdict.
  always @(posedge clk) begin
    logic [VERDICT_W-1:0] want;
    logic [VERDICT_W-1:0] got;
    if (rst_n) begin
      if (in_tvalid && !in_tready) input_stall_cycles++;
      if (out_tvalid && out_tready) begin
        got = out_tdata[VERDICT_W-1:0];
        if (pending_verdicts.size() == 0) begin
          $display("%0t: verdict with nothing expected, expected none, actual %0d",
                   $time, got);
          n_errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got !== want) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
            n_errors++;
          end else if (got <= VERDICT_SECOND) begin
            verdicts_seen[got]++;
          end
        end
      end
    end
  end

  // Hang detector: any transfer on any port restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
               $time, quiet_cycles, pending_verdicts.size());
      $display("FAIL constrained_pareto_dominance");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    penalty_skip = 1'b0;
    viol_first_sum = 0;
    viol_second_sum = 0;
    first_lower = 1'b0;
    second_lower = 1'b0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    n_errors = 0;
    pairs_sent = 0;
    input_stall_cycles = 0;
    verdicts_seen = '{0, 0, 0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_value();
    test_directed_constrained();
    test_violation_saturation();
    test_penalty_skip();
    test_random_modes();
    test_back_to_back();
    test_result_backpressure();
    wait_drained();

    $display("Run covered %0d element pairs in both penalty modes, including saturated sums.",
             pairs_sent);
    $display("Verdicts none/first/second: %0d/%0d/%0d; input held off for %0d cycles.",
             verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], input_stall_cycles);
    if (n_errors == 0) begin
      $display("PASS constrained_pareto_dominance");
    end else begin
      $display("FAIL constrained_pareto_dominance");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cpd_pkg.sv
rtl/cpd_accum.sv
rtl/cpd_verdict.sv
rtl/constrained_pareto_dominance.sv
bench/constrained_pareto_dominance_tb.sv
